// ----- hdl/gna_pkg.sv -----
// shared types, constants and the exp2 root table for the group norm accumulator
// no dependencies; every other file of the block uses it by scoped names
package gna_pkg;

  localparam int unsigned GrpW   = 56;
  localparam int unsigned SumW   = 48;
  localparam int unsigned ExpW   = 20;
  localparam int unsigned InExpW = 16;
  localparam int unsigned FracW  = 40;
  localparam int unsigned MaxIters = 40;
  localparam int unsigned QueueDepth = 4;

  localparam logic [GrpW-1:0] GrpMax = '1;
  localparam logic [SumW-1:0] SumMax = '1;
  localparam logic [5:0] GrpFrac = 6'd38;
  localparam logic [5:0] ColFrac = 6'd24;

  // register indexes of the configuration port
  localparam logic RegInnerExp = 1'b0;
  localparam logic RegOuterExp = 1'b1;

  typedef struct packed {
    logic              term_valid;
    logic signed [15:0] v_value;
    logic [15:0]       weight_sq;
    logic              group_end;
    logic              column_end;
    logic              matrix_end;
  } gna_in_t;

  typedef struct packed {
    logic [47:0] omega_value;
    logic        saturated;
  } gna_out_t;

  // one closed group handed from front to back
  typedef struct packed {
    logic [GrpW-1:0] grp_sum;
    logic            grp_sat;
    logic            col_end;
    logic            mat_end;
  } gna_qent_t;

  typedef struct packed {
    logic [GrpW-1:0] x;
    logic [5:0]      frac;
    logic [ExpW-1:0] e;
  } gna_pow_req_t;

  typedef struct packed {
    logic [SumW-1:0] y;
    logic            ovf;
  } gna_pow_rsp_t;

  typedef enum logic [1:0] {F_IDLE, F_SQ, F_MUL, F_ADD} gna_front_e;
  typedef enum logic [2:0] {B_IDLE, B_GRP, B_COL_START, B_COL, B_EMIT} gna_back_e;
  typedef enum logic [3:0] {
    P_IDLE, P_NORM, P_LOG, P_MAG, P_MULH, P_MULL, P_SPLIT, P_EXP, P_FINAL
  } gna_pow_e;

  typedef logic [31:0] gna_root_tab_t [MaxIters];

  // successive square roots of 2 in Q2.30, each by truncated integer sqrt
  function automatic gna_root_tab_t gen_roots();
    gna_root_tab_t t;
    logic [63:0] r;
    logic [63:0] a;
    logic [63:0] res;
    logic [63:0] b;
    r = 64'd1 << 31;
    for (int k = 0; k < MaxIters; k++) begin
      a = r << 30;
      res = '0;
      b = 64'd1 << 62;
      while (b > a) b = b >> 2;
      while (b != 0) begin
        if (a >= res + b) begin
          a = a - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      r = res;
      t[k] = res[31:0];
    end
    return t;
  endfunction

  localparam gna_root_tab_t ExpRoots = gen_roots();

endpackage

// ----- hdl/gna_front.sv -----
// front end: accepts items, forms v^2 * w and accumulates the group sum
// pushes each closed group into the queue; uses gna_pkg
module gna_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  gna_pkg::gna_in_t    in_data_i,
  output logic                push_o,
  output gna_pkg::gna_qent_t  push_data_o,
  input  logic                full_i
);

  gna_pkg::gna_front_e state_q, state_d;
  gna_pkg::gna_in_t    item_q, item_d;
  logic [30:0] sq_q, sq_d;
  logic [46:0] term_q, term_d;
  logic [gna_pkg::GrpW-1:0] grp_q, grp_d;
  logic grp_sat_q, grp_sat_d;

  logic signed [31:0] sq_full;
  logic [gna_pkg::GrpW:0] sum_wide;
  logic [gna_pkg::GrpW-1:0] sum_sat;
  logic add_ovf;
  logic close;

  assign sq_full  = item_q.v_value * item_q.v_value;
  assign sum_wide = {1'b0, grp_q} + (gna_pkg::GrpW+1)'(term_q);
  assign add_ovf  = sum_wide[gna_pkg::GrpW];
  assign sum_sat  = add_ovf ? gna_pkg::GrpMax : sum_wide[gna_pkg::GrpW-1:0];
  assign close    = item_q.group_end | item_q.column_end | item_q.matrix_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= gna_pkg::F_IDLE;
      grp_q     <= '0;
      grp_sat_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      grp_q     <= grp_d;
      grp_sat_q <= grp_sat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    sq_q   <= sq_d;
    term_q <= term_d;
  end

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    sq_d        = sq_q;
    term_d      = term_q;
    grp_d       = grp_q;
    grp_sat_d   = grp_sat_q;
    in_ready_o  = 1'b0;
    push_o      = 1'b0;
    push_data_o = '{grp_sum: sum_sat, grp_sat: grp_sat_q | add_ovf,
                    col_end: item_q.column_end | item_q.matrix_end,
                    mat_end: item_q.matrix_end};
    case (state_q)
      gna_pkg::F_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          item_d  = in_data_i;
          state_d = gna_pkg::F_SQ;
        end
      end
      gna_pkg::F_SQ: begin
        sq_d    = sq_full[30:0];
        state_d = gna_pkg::F_MUL;
      end
      gna_pkg::F_MUL: begin
        term_d  = item_q.term_valid ? 47'(sq_q * item_q.weight_sq) : '0;
        state_d = gna_pkg::F_ADD;
      end
      gna_pkg::F_ADD: begin
        if (close) begin
          // hold the term until the queue has room
          if (!full_i) begin
            push_o    = 1'b1;
            grp_d     = '0;
            grp_sat_d = 1'b0;
            state_d   = gna_pkg::F_IDLE;
          end
        end else begin
          grp_d     = sum_sat;
          grp_sat_d = grp_sat_q | add_ovf;
          state_d   = gna_pkg::F_IDLE;
        end
      end
      default: state_d = gna_pkg::F_IDLE;
    endcase
  end

endmodule

// ----- hdl/gna_queue.sv -----
// short fifo of closed groups between front and back
// register storage with a single read port; uses gna_pkg
module gna_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  gna_pkg::gna_qent_t  push_data_i,
  input  logic                pop_i,
  output gna_pkg::gna_qent_t  head_o,
  output logic                full_o,
  output logic                empty_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  gna_pkg::gna_qent_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ----- hdl/gna_pow.sv -----
// iterative fixed-point power unit: exp2(e * log2(x)), result in Q24.24
// one log bit and one exp factor per cycle; uses gna_pkg
module gna_pow #(
  parameter int unsigned Iters = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  gna_pkg::gna_pow_req_t req_i,
  output logic                  done_o,
  output gna_pkg::gna_pow_rsp_t rsp_o
);

  localparam int unsigned StepW = $clog2(Iters);

  gna_pkg::gna_pow_e state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic [63:0] xn_q, xn_d;
  logic [5:0]  lz_q, lz_d;
  logic [5:0]  frac_q, frac_d;
  logic [gna_pkg::ExpW-1:0] e_q, e_d;
  logic [30:0] z_q, z_d;
  logic [39:0] lf_q, lf_d;
  logic neg_q, neg_d;
  logic [45:0] mag_q, mag_d;
  logic [45:0] ph_q, ph_d;
  logic [39:0] pl_q, pl_d;
  logic signed [17:0] yi_q, yi_d;
  logic [39:0] yf_q, yf_d;
  logic [31:0] mant_q, mant_d;
  logic done_q, done_d;
  gna_pkg::gna_pow_rsp_t rsp_q, rsp_d;

  logic [5:0]  nsh;
  logic [63:0] nmask;
  logic [5:0]  bidx;
  logic [61:0] zz;
  logic [63:0] mm;
  logic signed [7:0]  ip;
  logic signed [47:0] lg;
  logic [47:0] lg_abs;
  logic [55:0] prod;
  logic [15:0] pint;
  logic [39:0] pfr;
  logic [4:0]  lsh;
  logic signed [17:0] rsh;
  logic [63:0] vup;

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  always_comb begin
    case (step_q[2:0])
      3'd0:    nsh = 6'd32;
      3'd1:    nsh = 6'd16;
      3'd2:    nsh = 6'd8;
      3'd3:    nsh = 6'd4;
      3'd4:    nsh = 6'd2;
      default: nsh = 6'd1;
    endcase
  end

  assign nmask  = ~(64'hFFFF_FFFF_FFFF_FFFF >> nsh);
  assign bidx   = 6'd39 - 6'(step_q);
  assign zz     = z_q * z_q;
  assign mm     = mant_q * gna_pkg::ExpRoots[6'(step_q)];
  assign ip     = $signed({2'b00, 6'd63 - lz_q}) - $signed({2'b00, frac_q});
  assign lg     = {ip, lf_q};
  assign lg_abs = lg[47] ? 48'(-lg) : 48'(lg);
  assign prod   = {2'b00, ph_q, 8'h00} + 56'(pl_q >> 12);
  assign pint   = prod[55:40];
  assign pfr    = prod[39:0];
  assign lsh    = 5'(yi_q - 18'sd6);
  assign rsh    = 18'sd6 - yi_q;
  assign vup    = {32'h0, mant_q} << lsh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gna_pkg::P_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    xn_q   <= xn_d;
    lz_q   <= lz_d;
    frac_q <= frac_d;
    e_q    <= e_d;
    z_q    <= z_d;
    lf_q   <= lf_d;
    neg_q  <= neg_d;
    mag_q  <= mag_d;
    ph_q   <= ph_d;
    pl_q   <= pl_d;
    yi_q   <= yi_d;
    yf_q   <= yf_d;
    mant_q <= mant_d;
    rsp_q  <= rsp_d;
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    xn_d    = xn_q;
    lz_d    = lz_q;
    frac_d  = frac_q;
    e_d     = e_q;
    z_d     = z_q;
    lf_d    = lf_q;
    neg_d   = neg_q;
    mag_d   = mag_q;
    ph_d    = ph_q;
    pl_d    = pl_q;
    yi_d    = yi_q;
    yf_d    = yf_q;
    mant_d  = mant_q;
    rsp_d   = rsp_q;
    done_d  = 1'b0;
    case (state_q)
      gna_pkg::P_IDLE: begin
        if (start_i) begin
          xn_d   = {8'h00, req_i.x};
          frac_d = req_i.frac;
          e_d    = req_i.e;
          lz_d   = '0;
          step_d = '0;
          lf_d   = '0;
          if (req_i.x == '0) begin
            rsp_d  = '{y: '0, ovf: 1'b0};
            done_d = 1'b1;
          end else begin
            state_d = gna_pkg::P_NORM;
          end
        end
      end
      gna_pkg::P_NORM: begin
        // binary search for the leading one, one shift size per cycle
        if ((xn_q & nmask) == '0) begin
          xn_d = xn_q << nsh;
          lz_d = lz_q + nsh;
        end
        if (step_q == StepW'(5)) begin
          // mantissa in Q1.30 from the normalized value
          z_d     = xn_d[63:33];
          step_d  = '0;
          state_d = gna_pkg::P_LOG;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      gna_pkg::P_LOG: begin
        if (zz[61]) begin
          lf_d[bidx] = 1'b1;
          z_d = zz[61:31];
        end else begin
          z_d = zz[60:30];
        end
        if (step_q == StepW'(Iters - 1)) begin
          state_d = gna_pkg::P_MAG;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      gna_pkg::P_MAG: begin
        neg_d   = lg[47];
        mag_d   = lg_abs[45:0];
        state_d = gna_pkg::P_MULH;
      end
      gna_pkg::P_MULH: begin
        ph_d    = mag_q[45:20] * e_q;
        state_d = gna_pkg::P_MULL;
      end
      gna_pkg::P_MULL: begin
        pl_d    = mag_q[19:0] * e_q;
        state_d = gna_pkg::P_SPLIT;
      end
      gna_pkg::P_SPLIT: begin
        mant_d = 32'd1 << 30;
        step_d = '0;
        if (!neg_q) begin
          yi_d = $signed({2'b00, pint});
          yf_d = pfr;
          if (pint >= 16'd24) begin
            rsp_d   = '{y: gna_pkg::SumMax, ovf: 1'b1};
            done_d  = 1'b1;
            state_d = gna_pkg::P_IDLE;
          end else begin
            state_d = gna_pkg::P_EXP;
          end
        end else begin
          // floor of a negative value: borrow one when a fraction remains
          yi_d    = $signed(18'd0 - {2'b00, pint} - {17'd0, (pfr != '0)});
          yf_d    = 40'd0 - pfr;
          state_d = gna_pkg::P_EXP;
        end
      end
      gna_pkg::P_EXP: begin
        if (yf_q[bidx]) begin
          mant_d = mm[61:30];
        end
        if (step_q == StepW'(Iters - 1)) begin
          state_d = gna_pkg::P_FINAL;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      gna_pkg::P_FINAL: begin
        if (yi_q >= 18'sd6) begin
          if (vup > 64'(gna_pkg::SumMax)) begin
            rsp_d = '{y: gna_pkg::SumMax, ovf: 1'b1};
          end else begin
            rsp_d = '{y: vup[47:0], ovf: 1'b0};
          end
        end else if (rsh > 18'sd31) begin
          rsp_d = '{y: '0, ovf: 1'b0};
        end else begin
          rsp_d = '{y: 48'(mant_q >> rsh[4:0]), ovf: 1'b0};
        end
        done_d  = 1'b1;
        state_d = gna_pkg::P_IDLE;
      end
      default: state_d = gna_pkg::P_IDLE;
    endcase
  end

endmodule

// ----- hdl/gna_back.sv -----
// back end: pops closed groups, raises them to the inner and outer powers,
// keeps column and total sums and the result register; uses gna_pkg
module gna_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [19:0]           cfg_data_i,
  input  logic                  empty_i,
  input  gna_pkg::gna_qent_t    head_i,
  output logic                  pop_o,
  output logic                  pow_start_o,
  output gna_pkg::gna_pow_req_t pow_req_o,
  input  logic                  pow_done_i,
  input  gna_pkg::gna_pow_rsp_t pow_rsp_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output gna_pkg::gna_out_t     out_data_o
);

  gna_pkg::gna_back_e state_q, state_d;
  logic [gna_pkg::InExpW-1:0] inner_q;
  logic [gna_pkg::ExpW-1:0]   outer_q;
  gna_pkg::gna_qent_t ent_q, ent_d;
  logic [gna_pkg::SumW-1:0] col_q, col_d, tot_q, tot_d;
  logic ovf_q, ovf_d;
  logic out_valid_q, out_valid_d;
  gna_pkg::gna_out_t out_q, out_d;

  logic [gna_pkg::SumW-1:0] add_a;
  logic [gna_pkg::SumW:0]   add_w;
  logic [gna_pkg::SumW-1:0] add_s;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // shared saturating adder for column and total
  assign add_a = (state_q == gna_pkg::B_COL) ? tot_q : col_q;
  assign add_w = {1'b0, add_a} + {1'b0, pow_rsp_i.y};
  assign add_s = add_w[gna_pkg::SumW] ? gna_pkg::SumMax : add_w[gna_pkg::SumW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gna_pkg::B_IDLE;
      inner_q     <= gna_pkg::InExpW'(1024);
      outer_q     <= gna_pkg::ExpW'(8192);
      col_q       <= '0;
      tot_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      tot_q       <= tot_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          gna_pkg::RegInnerExp: inner_q <= cfg_data_i[gna_pkg::InExpW-1:0];
          gna_pkg::RegOuterExp: outer_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
    out_q <= out_d;
  end

  always_comb begin
    state_d     = state_q;
    ent_d       = ent_q;
    col_d       = col_q;
    tot_d       = tot_q;
    ovf_d       = ovf_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    pop_o       = 1'b0;
    pow_start_o = 1'b0;
    pow_req_o   = '{x: head_i.grp_sum, frac: gna_pkg::GrpFrac,
                    e: gna_pkg::ExpW'(inner_q)};
    case (state_q)
      gna_pkg::B_IDLE: begin
        if (!empty_i) begin
          pop_o       = 1'b1;
          pow_start_o = 1'b1;
          ent_d       = head_i;
          state_d     = gna_pkg::B_GRP;
        end
      end
      gna_pkg::B_GRP: begin
        if (pow_done_i) begin
          col_d = add_s;
          ovf_d = ovf_q | pow_rsp_i.ovf | add_w[gna_pkg::SumW] | ent_q.grp_sat;
          state_d = ent_q.col_end ? gna_pkg::B_COL_START : gna_pkg::B_IDLE;
        end
      end
      gna_pkg::B_COL_START: begin
        pow_start_o = 1'b1;
        pow_req_o   = '{x: gna_pkg::GrpW'(col_q), frac: gna_pkg::ColFrac, e: outer_q};
        col_d       = '0;
        state_d     = gna_pkg::B_COL;
      end
      gna_pkg::B_COL: begin
        if (pow_done_i) begin
          tot_d   = add_s;
          ovf_d   = ovf_q | pow_rsp_i.ovf | add_w[gna_pkg::SumW];
          state_d = ent_q.mat_end ? gna_pkg::B_EMIT : gna_pkg::B_IDLE;
        end
      end
      gna_pkg::B_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = '{omega_value: tot_q, saturated: ovf_q};
          out_valid_d = 1'b1;
          tot_d       = '0;
          ovf_d       = 1'b0;
          state_d     = gna_pkg::B_IDLE;
        end
      end
      default: state_d = gna_pkg::B_IDLE;
    endcase
  end

endmodule

// ----- hdl/group_norm_accumulator_top.sv -----
// top level of the weighted group norm accumulator: front, queue, back, power unit
// depends on gna_pkg, gna_front, gna_queue, gna_pow, gna_back
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid_i, in_ready_o, in_data_i        | request in
//  out     | out_valid_o, out_ready_i, out_data_o     | request out
//  cfg     | cfg_we_i, cfg_idx_i, cfg_data_i          | write only
//
// the front takes no new request until the last has left its square, multiply
// and add states; it stalls only when a closing request finds the group queue full
// each group close takes one pass through the power unit, a column close
// a second pass; the power unit sets the sustained rate
// the result register frees the back end while an emitted total waits
// reset clears all sums, the flag, the queue and restores default exponents
module group_norm_accumulator_top #(
  parameter int unsigned EXP_LOG_ITERATIONS = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  gna_pkg::gna_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output gna_pkg::gna_out_t out_data_o,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [19:0]       cfg_data_i
);

  logic q_push, q_pop, q_full, q_empty;
  gna_pkg::gna_qent_t q_wdata, q_head;
  logic pow_start, pow_done;
  gna_pkg::gna_pow_req_t pow_req;
  gna_pkg::gna_pow_rsp_t pow_rsp;

  gna_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .push_o      (q_push),
    .push_data_o (q_wdata),
    .full_i      (q_full)
  );

  gna_queue #(.Depth(gna_pkg::QueueDepth)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  gna_pow #(.Iters(EXP_LOG_ITERATIONS)) u_pow (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (pow_start),
    .req_i   (pow_req),
    .done_o  (pow_done),
    .rsp_o   (pow_rsp)
  );

  gna_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .empty_i     (q_empty),
    .head_i      (q_head),
    .pop_o       (q_pop),
    .pow_start_o (pow_start),
    .pow_req_o   (pow_req),
    .pow_done_i  (pow_done),
    .pow_rsp_i   (pow_rsp),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full) else $error("group pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty) else $error("group popped from empty queue");

  a_no_start_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pow_done |-> !pow_start) else $error("power started while result pending");

  a_front_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o) else $error("front took two requests");

endmodule
